>>> rtl/rgbds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbds_pkg
// Shared types and constants for the 2x2 RGB box-filter downsampler.
// ----------------------------------------------------------------------------
package rgbds_pkg;

    // configuration register file
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_IMAGE_WIDTH  = 1'b0;
    localparam cfg_idx_t REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

    // row position
    localparam int ROW_LIMIT = 2048;
    localparam int ROW_W     = 11;

    typedef logic [ROW_W-1:0] row_t;

endpackage

>>> rtl/rgb_two_by_two_downsampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_two_by_two_downsampler_top
// 2x2 box-filter downsampler for an RGB raster stream, rounded half up.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock and, after the request of the bottom-right
// pixel of each 2x2 block, presents the rounded block average through the
// line-buffer read stage and then the output register. Throughput is one pixel
// per cycle; the input stalls only when both the line-buffer read stage and
// the output register hold results that the sink has not taken. Even-row pair
// sums sit in a single-port line buffer of MAX_WIDTH/2 entries with a
// registered read. The buffer has no reset and needs no clearing pass. An odd
// last column or row is consumed without output; frame_last marks the frame's
// bottom-right output. Write image_width and image_height only while idle.
// ----------------------------------------------------------------------------
module rgb_two_by_two_downsampler_top
    import rgbds_pkg::*;
#(
    parameter int MAX_WIDTH    = 2048,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_we,
    input  cfg_idx_t                cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CHANNEL_BITS-1:0] s_red_in,
    input  logic [CHANNEL_BITS-1:0] s_green_in,
    input  logic [CHANNEL_BITS-1:0] s_blue_in,
    input  logic                    s_frame_start,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CHANNEL_BITS-1:0] m_red_out,
    output logic [CHANNEL_BITS-1:0] m_green_out,
    output logic [CHANNEL_BITS-1:0] m_blue_out,
    output logic                    m_frame_last
);

    localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int PB         = CHANNEL_BITS + 1;
    localparam int QB         = CHANNEL_BITS + 2;
    localparam int CW         = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    localparam logic [CW-1:0]    MAX_W_C  = CW'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] ROW_LIM_C = CFG_W'(ROW_LIMIT);

    // configuration
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;

    // position and pair state
    logic [COL_W-1:0]  col_count_reg, col_count_next;
    row_t              row_count_reg, row_count_next;
    logic [3*PB-1:0]   pair_sum_reg;

    // line buffer and read stage
    logic [3*PB-1:0]   line_mem [LINE_DEPTH];
    logic [3*PB-1:0]   above_reg;
    logic [3*PB-1:0]   sums_reg;
    logic              last_reg;
    logic              b_valid_reg;

    // output register
    logic              m_valid_reg;
    logic [CHANNEL_BITS-1:0] red_reg, green_reg, blue_reg;
    logic              frame_last_reg;

    // combinational
    logic [CW-1:0]     width_ext, w_clamp;
    logic [COL_W:0]    eff_w, used_w;
    logic [CFG_W-1:0]  eff_h, used_h;
    logic [COL_W-1:0]  col_cur;
    row_t              row_cur;
    logic [COL_W:0]    col_inc;
    logic [CFG_W-1:0]  row_inc;
    logic              in_area, col_odd, row_odd;
    logic              accept, en_out;
    logic              do_write, do_emit, is_last;
    logic [ADDR_W-1:0] line_addr;
    logic [COL_W-1:0]  col_half;
    logic [3*PB-1:0]   px_packed, sums_packed;
    logic [CHANNEL_BITS-1:0] px [3];
    logic [CHANNEL_BITS-1:0] avg [3];
    logic [QB-1:0]     quad [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp the frame size
    always_comb begin
        width_ext = CW'(image_width_reg);
        if (width_ext == '0) begin
            w_clamp = CW'(1);
        end else if (width_ext > MAX_W_C) begin
            w_clamp = MAX_W_C;
        end else begin
            w_clamp = width_ext;
        end
        eff_w  = w_clamp[COL_W:0];
        used_w = {eff_w[COL_W:1], 1'b0};

        if (image_height_reg == '0) begin
            eff_h = CFG_W'(1);
        end else if (image_height_reg > ROW_LIM_C) begin
            eff_h = ROW_LIM_C;
        end else begin
            eff_h = image_height_reg;
        end
        used_h = {eff_h[CFG_W-1:1], 1'b0};
    end

    assign en_out  = !m_valid_reg || m_ready;
    assign s_ready = !b_valid_reg || en_out;
    assign accept  = s_valid && s_ready;

    assign px[0] = s_red_in;
    assign px[1] = s_green_in;
    assign px[2] = s_blue_in;

    always_comb begin
        col_cur = s_frame_start ? '0 : col_count_reg;
        row_cur = s_frame_start ? '0 : row_count_reg;

        in_area = ({1'b0, col_cur} < used_w) && ({1'b0, row_cur} < used_h);
        col_odd = col_cur[0];
        row_odd = row_cur[0];
        is_last = ({1'b0, col_cur} == used_w - 1'b1) &&
                  ({1'b0, row_cur} == used_h - 1'b1);

        do_write = accept && in_area && col_odd && !row_odd;
        do_emit  = accept && in_area && col_odd && row_odd;

        col_half  = col_cur >> 1;
        line_addr = col_half[ADDR_W-1:0];

        for (int ch = 0; ch < 3; ch++) begin
            px_packed[ch*PB +: PB]   = {1'b0, px[ch]};
            sums_packed[ch*PB +: PB] = pair_sum_reg[ch*PB +: PB] + PB'(px[ch]);
        end

        // advance the raster position, wrap at row and frame end
        col_inc = {1'b0, col_cur} + 1'b1;
        row_inc = {1'b0, row_cur} + 1'b1;
        col_count_next = col_inc[COL_W-1:0];
        row_count_next = row_cur;
        if (col_inc >= eff_w) begin
            col_count_next = '0;
            row_count_next = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            pair_sum_reg  <= '0;
        end else if (accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            if (in_area && !col_odd) begin
                pair_sum_reg <= px_packed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            line_mem[line_addr] <= sums_packed;
        end
        if (do_emit) begin
            above_reg <= line_mem[line_addr];
        end
    end

    // read stage: hold while the output register is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_ready) begin
            b_valid_reg <= do_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            sums_reg <= sums_packed;
            last_reg <= is_last;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            quad[ch] = QB'(sums_reg[ch*PB +: PB]) + QB'(above_reg[ch*PB +: PB]) +
                       QB'(2);
            avg[ch]  = quad[ch][QB-1:2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_out) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out && b_valid_reg) begin
            red_reg        <= avg[0];
            green_reg      <= avg[1];
            blue_reg       <= avg[2];
            frame_last_reg <= last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red_out    = red_reg;
    assign m_green_out  = green_reg;
    assign m_blue_out   = blue_reg;
    assign m_frame_last = frame_last_reg;

    // input stalls only when both result stages are occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (b_valid_reg && m_valid_reg))
        else $error("input stalled with a free result stage");

    // an emitting request lands in the read stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        do_emit |=> b_valid_reg)
        else $error("emitted request lost before read stage");

    // a stalled read stage keeps its sums and buffer data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !en_out) |=> (b_valid_reg && $stable(sums_reg) &&
                                      $stable(above_reg)))
        else $error("read stage changed while stalled");

endmodule
